// ===== rtl/aid_pkg.sv =====
// Shared constants, types and state codes for the aligned identity distance unit.
// No dependencies; every other file in rtl/ refers to this package by scoped name.
package aid_pkg;

	localparam int CNT_W         = 17;
	localparam int MAX_COLUMNS   = 65536;
	localparam int CNT_WIDTH_MAX = 131071;
	localparam logic [CNT_W-1:0] CNT_CAP = (MAX_COLUMNS > CNT_WIDTH_MAX) ?
		CNT_W'(CNT_WIDTH_MAX) : CNT_W'(MAX_COLUMNS);

	localparam int FRAC_W = 16;
	localparam int DIST_W = 18;
	localparam logic [DIST_W-1:0] Q_ONE = DIST_W'(65536);

	localparam int AVG_W = 14;
	localparam logic [AVG_W-1:0] LEN_CAP = AVG_W'(10000);

	// floor(avg * 65536 / 10000) for avg up to LEN_CAP is (avg * LEN_RECIP) >> RECIP_SHIFT
	localparam int RECIP_W     = 26;
	localparam int RECIP_SHIFT = 23;
	localparam logic [RECIP_W-1:0] LEN_RECIP = RECIP_W'(54975582);

	localparam int RES_W = 8;
	localparam int LEN_W = 16;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;
	localparam logic [CFG_IDX_W-1:0] REG_GAP_CODE  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_LEN_BONUS = CFG_IDX_W'(1);
	localparam logic [RES_W-1:0] GAP_CODE_RESET = RES_W'(45);

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	localparam int DIV_STEPS = CNT_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

	typedef struct packed {
		logic [CNT_W-1:0] match_cnt;
		logic [CNT_W-1:0] aligned;
		logic [AVG_W-1:0] avg;
	} job_t;

	typedef struct packed {
		logic             start;
		logic [CNT_W-1:0] num;
		logic [CNT_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [CNT_W-1:0] quo;
	} div_rsp_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_DIV_ID,
		BK_WAIT_OUT
	} back_state_t;

endpackage

// ===== rtl/aid_front.sv =====
// Front end: config registers, per-column gap/match classification and counters.
// Pushes one job per pair into the queue. Depends on aid_pkg.
module aid_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [aid_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [aid_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           accept,
	input  logic [aid_pkg::RES_W-1:0]      residue_a,
	input  logic [aid_pkg::RES_W-1:0]      residue_b,
	input  logic [aid_pkg::LEN_W-1:0]      length_a,
	input  logic [aid_pkg::LEN_W-1:0]      length_b,
	input  logic                           last_column,
	output logic                           push,
	output aid_pkg::job_t                  job
);

	logic [aid_pkg::RES_W-1:0] gap_code_q;
	logic                      bonus_en_q;
	logic [aid_pkg::CNT_W-1:0] matches_q;
	logic [aid_pkg::CNT_W-1:0] aligned_q;

	logic                      is_aligned;
	logic                      is_match;
	logic [aid_pkg::CNT_W-1:0] matches_nxt;
	logic [aid_pkg::CNT_W-1:0] aligned_nxt;
	logic [aid_pkg::LEN_W:0]   len_sum;
	logic [aid_pkg::LEN_W-1:0] len_avg;
	logic [aid_pkg::AVG_W-1:0] avg_capped;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_code_q <= aid_pkg::GAP_CODE_RESET;
			bonus_en_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				aid_pkg::REG_GAP_CODE:  gap_code_q <= cfg_data[aid_pkg::RES_W-1:0];
				aid_pkg::REG_LEN_BONUS: bonus_en_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		is_aligned  = (residue_a != gap_code_q) && (residue_b != gap_code_q);
		is_match    = is_aligned && (residue_a == residue_b);
		aligned_nxt = aligned_q;
		matches_nxt = matches_q;
		if (is_aligned) begin
			aligned_nxt = (aligned_q >= aid_pkg::CNT_CAP) ? aid_pkg::CNT_CAP
				: aligned_q + aid_pkg::CNT_W'(1);
		end
		if (is_match) begin
			matches_nxt = (matches_q >= aid_pkg::CNT_CAP) ? aid_pkg::CNT_CAP
				: matches_q + aid_pkg::CNT_W'(1);
		end
		len_sum = {1'b0, length_a} + {1'b0, length_b};
		len_avg = len_sum[aid_pkg::LEN_W:1];
		if (!bonus_en_q) begin
			avg_capped = '0;
		end else if (len_avg > aid_pkg::LEN_W'(aid_pkg::LEN_CAP)) begin
			avg_capped = aid_pkg::LEN_CAP;
		end else begin
			avg_capped = len_avg[aid_pkg::AVG_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			matches_q <= '0;
			aligned_q <= '0;
		end else if (accept) begin
			if (last_column) begin
				matches_q <= '0;
				aligned_q <= '0;
			end else begin
				matches_q <= matches_nxt;
				aligned_q <= aligned_nxt;
			end
		end
	end

	assign push          = accept && last_column;
	assign job.match_cnt = matches_nxt;
	assign job.aligned   = aligned_nxt;
	assign job.avg       = avg_capped;

endmodule

// ===== rtl/aid_queue.sv =====
// Short job queue between front and back ends.
// Depends on aid_pkg (depth and job type).
module aid_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  aid_pkg::job_t din,
	input  logic          pop,
	output logic          full,
	output logic          not_empty,
	output aid_pkg::job_t head
);

	aid_pkg::job_t              mem_q [aid_pkg::QUEUE_DEPTH];
	logic [aid_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [aid_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [aid_pkg::QPTR_W:0]   count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + aid_pkg::QPTR_W'(1);
			if (pop)  rd_ptr_q <= rd_ptr_q + aid_pkg::QPTR_W'(1);
			case ({push, pop})
				2'b10:   count_q <= count_q + (aid_pkg::QPTR_W+1)'(1);
				2'b01:   count_q <= count_q - (aid_pkg::QPTR_W+1)'(1);
				default: ;
			endcase
		end
	end

	assign full      = (count_q == (aid_pkg::QPTR_W+1)'(aid_pkg::QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = mem_q[rd_ptr_q];

endmodule

// ===== rtl/aid_div.sv =====
// Restoring divider, one quotient bit per cycle: quo = floor((num << 16) / den).
// Needs num >> 1 < den. Depends on aid_pkg.
module aid_div (
	input  logic              clk,
	input  logic              arst_n,
	input  aid_pkg::div_req_t req,
	output aid_pkg::div_rsp_t rsp
);

	logic [aid_pkg::CNT_W-1:0]     rem_q;
	logic [aid_pkg::CNT_W-1:0]     quo_q;
	logic [aid_pkg::CNT_W-1:0]     den_q;
	logic [aid_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                          done_q;

	logic [aid_pkg::CNT_W:0] trial;
	logic [aid_pkg::CNT_W:0] diff;
	logic                    ge;

	always_comb begin
		trial = {rem_q, quo_q[aid_pkg::CNT_W-1]};
		diff  = trial - {1'b0, den_q};
		ge    = (trial >= {1'b0, den_q});
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			// top bits of num<<16 seed the remainder, num[0] is the first bit shifted in
			rem_q <= {1'b0, req.num[aid_pkg::CNT_W-1:1]};
			quo_q <= {req.num[0], aid_pkg::FRAC_W'(0)};
			den_q <= req.den;
		end else if (cnt_q != '0) begin
			rem_q <= ge ? diff[aid_pkg::CNT_W-1:0] : trial[aid_pkg::CNT_W-1:0];
			quo_q <= {quo_q[aid_pkg::CNT_W-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == aid_pkg::DIV_CNT_W'(1)) && !req.start;
			if (req.start) begin
				cnt_q <= aid_pkg::DIV_CNT_W'(aid_pkg::DIV_STEPS);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - aid_pkg::DIV_CNT_W'(1);
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;

endmodule

// ===== rtl/aid_back.sv =====
// Back end: pops a job, runs the identity division, adds the length bonus, holds the result item.
// Depends on aid_pkg and aid_div.
module aid_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       job_valid,
	input  aid_pkg::job_t              job,
	output logic                       pop,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [aid_pkg::DIST_W-1:0] distance,
	output logic [aid_pkg::CNT_W-1:0]  match_count,
	output logic [aid_pkg::CNT_W-1:0]  aligned_count
);

	aid_pkg::back_state_t state_q, state_nxt;
	aid_pkg::div_req_t    div_req;
	aid_pkg::div_rsp_t    div_rsp;

	logic [aid_pkg::CNT_W-1:0]  matches_q;
	logic [aid_pkg::CNT_W-1:0]  aligned_q;
	logic [aid_pkg::AVG_W-1:0]  avg_q;
	logic [aid_pkg::CNT_W-1:0]  bonus_q;
	logic [aid_pkg::DIST_W-1:0] dist_q;
	logic                       out_valid_q;
	logic [aid_pkg::DIST_W-1:0] distance_q;
	logic [aid_pkg::CNT_W-1:0]  match_count_q;
	logic [aid_pkg::CNT_W-1:0]  aligned_count_q;

	logic [aid_pkg::CNT_W-1:0]                 q_id;
	logic [aid_pkg::AVG_W+aid_pkg::RECIP_W-1:0] bonus_prod;

	logic ld_dist;
	logic ld_out;

	aid_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= aid_pkg::BK_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt     = state_q;
		pop           = 1'b0;
		ld_dist       = 1'b0;
		ld_out        = 1'b0;
		div_req.start = 1'b0;
		div_req.num   = job.match_cnt;
		div_req.den   = job.aligned;
		case (state_q)
			aid_pkg::BK_IDLE: begin
				if (job_valid) begin
					pop           = 1'b1;
					div_req.start = 1'b1;
					state_nxt     = aid_pkg::BK_DIV_ID;
				end
			end
			aid_pkg::BK_DIV_ID: begin
				if (div_rsp.done) begin
					ld_dist   = 1'b1;
					state_nxt = aid_pkg::BK_WAIT_OUT;
				end
			end
			aid_pkg::BK_WAIT_OUT: begin
				if (!out_valid_q || out_ready) begin
					ld_out    = 1'b1;
					state_nxt = aid_pkg::BK_IDLE;
				end
			end
			default: state_nxt = aid_pkg::BK_IDLE;
		endcase
	end

	// nothing aligned: quotient taken as zero, so the identity term is 1.0
	assign q_id = (aligned_q == '0) ? '0 : div_rsp.quo;

	// length bonus by reciprocal multiply; avg_q holds still while the divider runs
	assign bonus_prod = {aid_pkg::RECIP_W'(0), avg_q} * {aid_pkg::AVG_W'(0), aid_pkg::LEN_RECIP};

	always_ff @(posedge clk) begin
		if (pop) begin
			matches_q <= job.match_cnt;
			aligned_q <= job.aligned;
			avg_q     <= job.avg;
		end
		bonus_q <= bonus_prod[aid_pkg::RECIP_SHIFT +: aid_pkg::CNT_W];
		if (ld_dist) begin
			dist_q <= aid_pkg::Q_ONE - {1'b0, q_id} + {1'b0, bonus_q};
		end
		if (ld_out) begin
			distance_q      <= dist_q;
			match_count_q   <= matches_q;
			aligned_count_q <= aligned_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ld_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid     = out_valid_q;
	assign distance      = distance_q;
	assign match_count   = match_count_q;
	assign aligned_count = aligned_count_q;

endmodule

// ===== rtl/aligned_identity_distance_unit.sv =====
// Aligned identity distance unit: one alignment column per cycle while in_ready is high,
// one result item per pair. A pair's counts go from the front end through the job queue
// to the bit-per-cycle divider in the back end and then to the output register.
// The back end takes a new pair only once the last result item is loaded, with a
// four-entry job queue so a burst of short pairs is absorbed before in_ready drops.
// Reset (arst_n low, asynchronous): counters, queue and output cleared, gap_code 45, bonus off.
module aligned_identity_distance_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	// configuration write port
	input  logic                           cfg_we,
	input  logic [aid_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [aid_pkg::CFG_DATA_W-1:0] cfg_data,
	// column channel
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [aid_pkg::RES_W-1:0]      residue_a,
	input  logic [aid_pkg::RES_W-1:0]      residue_b,
	input  logic [aid_pkg::LEN_W-1:0]      length_a,
	input  logic [aid_pkg::LEN_W-1:0]      length_b,
	input  logic                           last_column,
	// result channel
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [aid_pkg::DIST_W-1:0]     distance,
	output logic [aid_pkg::CNT_W-1:0]      match_count,
	output logic [aid_pkg::CNT_W-1:0]      aligned_count
);

	logic          accept;
	logic          push;
	logic          q_full;
	logic          q_not_empty;
	logic          pop;
	aid_pkg::job_t push_job;
	aid_pkg::job_t head_job;

	// Columns are held off only while the job queue is full, so the front end
	// keeps counting the next pair while the back end divides.
	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	// Front: classifies each column, keeps the saturating counters, and on the
	// last column hands on the final counts and capped mean length (zero if bonus off).
	aid_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.accept      (accept),
		.residue_a   (residue_a),
		.residue_b   (residue_b),
		.length_a    (length_a),
		.length_b    (length_b),
		.last_column (last_column),
		.push        (push),
		.job         (push_job)
	);

	aid_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.din       (push_job),
		.pop       (pop),
		.full      (q_full),
		.not_empty (q_not_empty),
		.head      (head_job)
	);

	// Back: matches/aligned quotient through the divider while the length bonus
	// comes from a reciprocal multiply, then the result item sits in an output
	// register until taken.
	aid_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.job_valid     (q_not_empty),
		.job           (head_job),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.distance      (distance),
		.match_count   (match_count),
		.aligned_count (aligned_count)
	);

endmodule

// ===== bench/aid_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for the aligned identity distance unit: watches the register port and both item
// channels, predicts each pair's result and compares it field by field. Needs aid_pkg only.
module aid_checker
	import aid_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	input  logic                  in_ready,
	input  logic [RES_W-1:0]      residue_a,
	input  logic [RES_W-1:0]      residue_b,
	input  logic [LEN_W-1:0]      length_a,
	input  logic [LEN_W-1:0]      length_b,
	input  logic                  last_column,
	input  logic                  out_valid,
	input  logic                  out_ready,
	input  logic [DIST_W-1:0]     distance,
	input  logic [CNT_W-1:0]      match_count,
	input  logic [CNT_W-1:0]      aligned_count,
	output int                    failures,
	output int                    pending,
	output int                    results_seen
);

	localparam int PRINT_LIMIT = 64;

	typedef struct packed {
		logic [DIST_W-1:0] distance;
		logic [CNT_W-1:0]  match_cnt;
		logic [CNT_W-1:0]  aligned;
	} pair_result_t;

	logic [RES_W-1:0] gap_code_q;
	logic             bonus_on_q;
	logic [CNT_W-1:0] run_matches;
	logic [CNT_W-1:0] run_aligned;
	pair_result_t     due_results[$];
	pair_result_t     want;
	pair_result_t     got;

	function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] v);
		return (v >= CNT_CAP) ? CNT_CAP : v + 1'b1;
	endfunction

	// 1.0 - matches/aligned in Q2.16, plus the capped mean-length term when enabled
	function automatic pair_result_t pair_distance(input logic [CNT_W-1:0] m,
			input logic [CNT_W-1:0] a, input logic [LEN_W-1:0] la,
			input logic [LEN_W-1:0] lb, input logic bonus);
		longint unsigned dist_val;
		longint unsigned mean;
		pair_result_t    r;
		if (a == '0)
			dist_val = Q_ONE;
		else
			dist_val = Q_ONE - ((longint'(m) << FRAC_W) / longint'(a));
		if (bonus) begin
			mean = (longint'(la) + longint'(lb)) / 2;
			if (mean > LEN_CAP)
				mean = LEN_CAP;
			dist_val += (mean << FRAC_W) / longint'(LEN_CAP);
		end
		r.distance  = dist_val[DIST_W-1:0];
		r.match_cnt = m;
		r.aligned   = a;
		return r;
	endfunction

	task automatic report_mismatch(input string field, input longint got_v, input longint want_v);
		if (failures < PRINT_LIMIT)
			$display("%0t: %s mismatch: got %0d, expected %0d", $realtime, field, got_v, want_v);
		failures++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_code_q   = GAP_CODE_RESET;
			bonus_on_q   = 1'b0;
			run_matches  = '0;
			run_aligned  = '0;
			due_results.delete();
			failures     = 0;
			pending      = 0;
			results_seen = 0;
		end else begin
			// spare indices leave both registers alone
			if (cfg_we) begin
				if (cfg_index == REG_GAP_CODE)
					gap_code_q = cfg_data[RES_W-1:0];
				else if (cfg_index == REG_LEN_BONUS)
					bonus_on_q = cfg_data[0];
			end
			if (in_valid && in_ready) begin
				if (residue_a != gap_code_q && residue_b != gap_code_q) begin
					run_aligned = bump(run_aligned);
					if (residue_a == residue_b)
						run_matches = bump(run_matches);
				end
				if (last_column) begin
					due_results.push_back(pair_distance(run_matches, run_aligned,
						length_a, length_b, bonus_on_q));
					run_matches = '0;
					run_aligned = '0;
				end
			end
			if (out_valid && out_ready) begin
				got.distance  = distance;
				got.match_cnt = match_count;
				got.aligned   = aligned_count;
				results_seen++;
				if (due_results.size() == 0) begin
					report_mismatch("unexpected result, distance", got.distance, -1);
				end else begin
					want = due_results.pop_front();
					if (got.distance !== want.distance)
						report_mismatch("distance", got.distance, want.distance);
					if (got.match_cnt !== want.match_cnt)
						report_mismatch("match_count", got.match_cnt, want.match_cnt);
					if (got.aligned !== want.aligned)
						report_mismatch("aligned_count", got.aligned, want.aligned);
				end
			end
			pending = due_results.size();
		end
	end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
// Top of the bench for aligned_identity_distance_unit: clock, reset, column stimulus,
// register writes and the verdict. Needs aid_pkg, the unit itself and aid_checker.
module tb;
	import aid_pkg::*;

	localparam real CLK_PERIOD     = 10.0;
	localparam int  RESET_CYCLES   = 8;
	// idle time after the last result so the back end goes quiet before a register write
	localparam int  DRAIN_CYCLES   = 64;
	// four queued pairs behind a heavily stalled receiver stay far below this
	localparam int  WATCHDOG_LIMIT = 4000;
	localparam int  ITEMS_PER_PASS = 150;

	// register indices the unit does not implement
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = CFG_IDX_W'(3);

	logic                  clk         = 1'b0;
	logic                  arst_n      = 1'b0;
	logic                  cfg_we      = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index   = '0;
	logic [CFG_DATA_W-1:0] cfg_data    = '0;
	logic                  in_valid    = 1'b0;
	logic                  in_ready;
	logic [RES_W-1:0]      residue_a   = '0;
	logic [RES_W-1:0]      residue_b   = '0;
	logic [LEN_W-1:0]      length_a    = '0;
	logic [LEN_W-1:0]      length_b    = '0;
	logic                  last_column = 1'b0;
	logic                  out_valid;
	logic                  out_ready   = 1'b0;
	logic [DIST_W-1:0]     distance;
	logic [CNT_W-1:0]      match_count;
	logic [CNT_W-1:0]      aligned_count;

	int               failures;
	int               pending;
	int               results_seen;
	int               send_idle_pct = 0;
	int               stall_pct     = 0;
	int               quiet_cycles  = 0;
	int               columns_sent  = 0;
	int               pairs_sent    = 0;
	logic [RES_W-1:0] cur_gap       = GAP_CODE_RESET;

	always #(CLK_PERIOD / 2) clk = ~clk;

	aligned_identity_distance_unit u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.residue_a     (residue_a),
		.residue_b     (residue_b),
		.length_a      (length_a),
		.length_b      (length_b),
		.last_column   (last_column),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.distance      (distance),
		.match_count   (match_count),
		.aligned_count (aligned_count)
	);

	aid_checker u_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.residue_a     (residue_a),
		.residue_b     (residue_b),
		.length_a      (length_a),
		.length_b      (length_b),
		.last_column   (last_column),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.distance      (distance),
		.match_count   (match_count),
		.aligned_count (aligned_count),
		.failures      (failures),
		.pending       (pending),
		.results_seen  (results_seen)
	);

	// Receiver back-pressure: redrawn every cycle, whether or not a result is up.
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= stall_pct);
	end

	// Watchdog: any accepted item on either channel resets the count.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no item moved for %0d cycles, %0d results outstanding",
					quiet_cycles, pending);
				$display("[aligned_identity_distance_unit] ERROR");
				$finish;
			end
		end
	end

	// Present one column and hold it until the unit takes it. The sender may sit idle
	// for a random stretch first; in_valid only drops during that idle stretch, so it is
	// never lowered and raised in the same step.
	task automatic send_column(input logic [RES_W-1:0] ra, input logic [RES_W-1:0] rb,
			input logic [LEN_W-1:0] la, input logic [LEN_W-1:0] lb, input logic last);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		residue_a   <= ra;
		residue_b   <= rb;
		length_a    <= la;
		length_b    <= lb;
		last_column <= last;
		do @(posedge clk); while (!in_ready);
		columns_sent++;
		if (last)
			pairs_sent++;
	endtask

	// Drop valid, wait for every predicted result, then let the back end go quiet
	// so a register write cannot land on a pair still in flight.
	task automatic settle();
		in_valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Back-to-back register writes; the enable drops once after the group.
	task automatic configure(input logic [RES_W-1:0] gap, input logic [CFG_DATA_W-1:0] bonus_word,
			input bit spare);
		cfg_we    <= 1'b1;
		cfg_index <= REG_GAP_CODE;
		cfg_data  <= gap;
		@(posedge clk);
		cfg_index <= REG_LEN_BONUS;
		cfg_data  <= bonus_word;
		@(posedge clk);
		if (spare) begin
			// would clobber gap code or turn the bonus off if decoded on one bit
			cfg_index <= REG_SPARE_LO;
			cfg_data  <= '0;
			@(posedge clk);
			cfg_index <= REG_SPARE_HI;
			cfg_data  <= 8'hFE;
			@(posedge clk);
		end
		cfg_we  <= 1'b0;
		cur_gap  = gap;
		@(posedge clk);
	endtask

	// Random pairs: mostly short, a few long, some single-column. Residues are biased
	// towards matches and gaps so the ratio takes many values. On the last column the
	// lengths are half the time drawn from zero up to twice the cap.
	task automatic random_pairs(input int items);
		int               sent;
		int               cols;
		int               shape;
		logic [RES_W-1:0] ra;
		logic [RES_W-1:0] rb;
		logic [LEN_W-1:0] la;
		logic [LEN_W-1:0] lb;
		sent = 0;
		while (sent < items) begin
			shape = $urandom_range(99);
			if (shape < 10)
				cols = 1;
			else if (shape < 85)
				cols = $urandom_range(8, 2);
			else
				cols = $urandom_range(40, 9);
			for (int c = 1; c <= cols; c++) begin
				ra = RES_W'($urandom);
				rb = ($urandom_range(99) < 45) ? ra : RES_W'($urandom);
				if ($urandom_range(99) < 15)
					ra = cur_gap;
				if ($urandom_range(99) < 15)
					rb = cur_gap;
				la = LEN_W'($urandom);
				lb = LEN_W'($urandom);
				if (c == cols && $urandom_range(1) == 1) begin
					la = LEN_W'($urandom_range(20000));
					lb = LEN_W'($urandom_range(20000));
				end
				send_column(ra, rb, la, lb, c == cols);
			end
			sent += cols;
		end
	endtask

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed, reset settings: gap '-', no bonus.
		send_column(8'd45, 8'd45, 16'hFFFF, 16'hFFFF, 1'b1);   // nothing aligned
		send_column(8'd0, 8'd0, 16'd0, 16'd0, 1'b1);           // one match
		send_column(8'd255, 8'd0, 16'd0, 16'hFFFF, 1'b1);      // one mismatch
		send_column(8'd45, 8'd65, 16'hFFFF, 16'd0, 1'b0);      // gap on either side only
		send_column(8'd65, 8'd45, 16'd0, 16'hFFFF, 1'b0);
		send_column(8'd65, 8'd65, 16'd3, 16'd4, 1'b1);
		send_column(8'd65, 8'd65, 16'd0, 16'd0, 1'b0);         // 2/3, truncated
		send_column(8'd66, 8'd67, 16'd0, 16'd0, 1'b0);
		send_column(8'd67, 8'd67, 16'd0, 16'd0, 1'b1);
		settle();

		// Directed, bonus on; the spare indices are written and must change nothing.
		configure(8'd45, 8'h81, 1'b1);
		send_column(8'd65, 8'd66, 16'd0, 16'd0, 1'b1);         // zero lengths
		send_column(8'd65, 8'd66, 16'hFFFF, 16'hFFFF, 1'b1);   // widest distance
		send_column(8'd65, 8'd65, 16'd9999, 16'd10001, 1'b1);  // mean right at the cap
		send_column(8'd45, 8'd65, 16'd19999, 16'd0, 1'b1);     // just under, nothing aligned
		send_column(8'd70, 8'd70, 16'd1, 16'd0, 1'b1);         // mean truncates to zero
		send_column(8'd0, 8'd255, 16'hFFFF, 16'd0, 1'b1);
		send_column(8'd45, 8'd45, 16'hFFFF, 16'hFFFF, 1'b0);
		send_column(8'd45, 8'd45, 16'd5000, 16'd5001, 1'b1);
		settle();

		// Random passes, each with its own settings and idling pattern.
		configure(8'd0, 8'h01, 1'b0);
		send_idle_pct = 0;
		stall_pct     = 0;
		random_pairs(ITEMS_PER_PASS);
		settle();

		configure(8'd255, 8'hFE, 1'b0);
		send_idle_pct = 83;
		stall_pct     = 0;
		random_pairs(ITEMS_PER_PASS);
		settle();

		configure(RES_W'($urandom), {7'($urandom), 1'b1}, 1'b0);
		send_idle_pct = 0;
		stall_pct     = 83;
		random_pairs(ITEMS_PER_PASS);
		settle();

		configure(GAP_CODE_RESET, 8'h00, 1'b0);
		send_idle_pct = 31;
		stall_pct     = 31;
		random_pairs(ITEMS_PER_PASS);
		settle();

		$display("sent %0d columns in %0d pairs, %0d results checked", columns_sent,
			pairs_sent, results_seen);
		$display("gap codes 0, 45, 255 and random; bonus on and off; idle and stall phases");
		if (failures == 0 && pending == 0)
			$display("[aligned_identity_distance_unit] OK");
		else
			$display("[aligned_identity_distance_unit] ERROR");
		$finish;
	end

endmodule
